/* sv/rld_pkg.sv */
// rld_pkg: types and constants shared by the run list decoder files
// no dependencies
`default_nettype none

package rld_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 64;

	// register index, taken from paddr[3]
	localparam logic REG_CLUSTER_SHIFT = 1'b0;
	localparam logic REG_IMAGE_BYTES   = 1'b1;

	localparam logic [4:0]  CLUSTER_SHIFT_RST = 5'd12;
	localparam logic [63:0] IMAGE_BYTES_RST   = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic [7:0] BYTE_MASK = 8'hFF;
	localparam logic [3:0] MAX_FIELD = 4'd8;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_OFFSET = 2'd2,
		PH_HALTED = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_EXTENT   = 3'd0,
		ST_OUTSIDE  = 3'd1,
		ST_ZERO_LEN = 3'd2,
		ST_END      = 3'd3,
		ST_TRUNC    = 3'd4
	} status_t;

	// one parsed byte as handed from the parser to the extent pipeline
	typedef struct packed {
		logic        clr;     // list start: running cluster restarts at zero
		logic        res;     // this byte produces a result
		logic        run;     // result is a complete non-empty run
		status_t     status;  // status when not a run
		logic [63:0] len;     // run length in clusters
		logic [63:0] off;     // sign-extended relative offset
	} run_ev_t;

endpackage

`default_nettype wire

/* sv/rld_if.sv */
// rld_in_if / rld_out_if: valid-ready channels of the run list decoder
// no dependencies
`default_nettype none

interface rld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] list_byte;
	logic       list_start;
	logic       list_last;

	modport source(output valid, output list_byte, output list_start, output list_last,
		input ready);
	modport sink(input valid, input list_byte, input list_start, input list_last,
		output ready);
endinterface

interface rld_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] start_byte;
	logic [63:0] length_byte;
	logic [63:0] cluster_number;

	modport source(output valid, output status, output start_byte, output length_byte,
		output cluster_number, input ready);
	modport sink(input valid, input status, input start_byte, input length_byte,
		input cluster_number, output ready);
endinterface

`default_nettype wire

/* sv/rld_regs.sv */
// rld_regs: apb-style configuration registers (cluster shift, image size)
// depends on rld_pkg
`default_nettype none

module rld_regs (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [rld_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rld_pkg::DATA_W-1:0] pwdata,
	output logic      [rld_pkg::DATA_W-1:0] prdata,
	output logic                          pready,
	output logic      [4:0]               cluster_shift,
	output logic      [63:0]              image_bytes
);
	import rld_pkg::*;

	logic [4:0]  cluster_shift_q;
	logic [63:0] image_bytes_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_shift_q <= CLUSTER_SHIFT_RST;
			image_bytes_q   <= IMAGE_BYTES_RST;
		end else if (wr_en) begin
			unique case (paddr[3])
				REG_CLUSTER_SHIFT: cluster_shift_q <= pwdata[4:0];
				REG_IMAGE_BYTES:   image_bytes_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_CLUSTER_SHIFT: prdata = {59'd0, cluster_shift_q};
			REG_IMAGE_BYTES:   prdata = image_bytes_q;
			default:           prdata = '0;
		endcase
	end

	assign cluster_shift = cluster_shift_q;
	assign image_bytes   = image_bytes_q;

endmodule

`default_nettype wire

/* sv/rld_parser.sv */
// rld_parser: byte-level run list parser with the first pipeline register
// depends on rld_pkg and rld_in_if
`default_nettype none

module rld_parser (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rld_in_if.sink        list_in,
	input  wire logic     take,
	output logic          v_s1,
	output rld_pkg::run_ev_t ev_s1
);
	import rld_pkg::*;

	phase_t      phase_q;
	logic [3:0]  len_size_q;
	logic [3:0]  off_size_q;
	logic [2:0]  idx_q;
	logic [63:0] len_acc_q;
	logic [63:0] off_acc_q;

	phase_t      ph, ph_n;
	logic [3:0]  ls, ls_n, os, os_n;
	logic [2:0]  idx, idx_n;
	logic [3:0]  idx_inc;
	logic [63:0] lacc, lacc_n, oacc, oacc_n;
	logic [7:0]  b;
	logic        finish;
	logic        acc;
	run_ev_t     ev_n;

	function automatic logic [3:0] clamp_size(input logic [3:0] n);
		return (n > MAX_FIELD) ? MAX_FIELD : n;
	endfunction

	// sign-extend an offset field of sz bytes (0 means offset zero)
	function automatic logic [63:0] sext(input logic [63:0] v, input logic [3:0] sz);
		logic [63:0] r;
		logic [5:0]  sidx;
		logic        sgn;
		sidx = {3'(sz[2:0] - 3'd1), 3'b111};
		sgn  = (sz != 4'd0) && (sz != MAX_FIELD) && v[sidx];
		for (int j = 0; j < 8; j++) begin
			r[j*8 +: 8] = (4'(j) < sz) ? v[j*8 +: 8] : {8{sgn}};
		end
		return r;
	endfunction

	assign acc           = list_in.valid & list_in.ready;
	assign list_in.ready = !v_s1 || take;

	always_comb begin
		b    = list_in.list_byte & BYTE_MASK;
		ph   = list_in.list_start ? PH_HEADER : phase_q;
		ls   = list_in.list_start ? 4'd0 : len_size_q;
		os   = list_in.list_start ? 4'd0 : off_size_q;
		idx  = list_in.list_start ? 3'd0 : idx_q;
		lacc = list_in.list_start ? 64'd0 : len_acc_q;
		oacc = list_in.list_start ? 64'd0 : off_acc_q;

		ph_n    = ph;
		ls_n    = ls;
		os_n    = os;
		idx_n   = idx;
		lacc_n  = lacc;
		oacc_n  = oacc;
		idx_inc = {1'b0, idx} + 4'd1;
		finish  = 1'b0;
		ev_n        = '0;
		ev_n.clr    = list_in.list_start;
		ev_n.status = ST_EXTENT;

		unique case (ph)
			PH_HEADER: begin
				ls_n   = clamp_size(b[3:0]);
				os_n   = clamp_size(b[7:4]);
				idx_n  = 3'd0;
				lacc_n = '0;
				oacc_n = '0;
				if (ls_n == 4'd0) begin
					ev_n.res    = 1'b1;
					ev_n.status = ST_END;
					ph_n        = PH_HALTED;
				end else begin
					ph_n = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				lacc_n[{idx, 3'b000} +: 8] = lacc[{idx, 3'b000} +: 8] | b;
				if (idx_inc >= ls) begin
					idx_n = 3'd0;
					if (os == 4'd0) finish = 1'b1;
					else ph_n = PH_OFFSET;
				end else begin
					idx_n = idx_inc[2:0];
				end
			end
			PH_OFFSET: begin
				oacc_n[{idx, 3'b000} +: 8] = oacc[{idx, 3'b000} +: 8] | b;
				if (idx_inc >= os) begin
					idx_n  = 3'd0;
					finish = 1'b1;
				end else begin
					idx_n = idx_inc[2:0];
				end
			end
			PH_HALTED: ;
			default: ;
		endcase

		if (finish) begin
			ev_n.res = 1'b1;
			if (lacc_n == 64'd0) begin
				ev_n.status = ST_ZERO_LEN;
				ph_n        = PH_HALTED;
			end else begin
				ev_n.run = 1'b1;
				ev_n.len = lacc_n;
				ev_n.off = sext(oacc_n, os);
				ph_n     = PH_HEADER;
				lacc_n   = '0;
				oacc_n   = '0;
			end
		end

		// last byte: cut the list short unless this byte already closed it
		if (list_in.list_last && ph != PH_HALTED) begin
			if (!ev_n.res) begin
				ev_n.res    = 1'b1;
				ev_n.status = ST_TRUNC;
			end
			ph_n = PH_HALTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			len_size_q <= '0;
			off_size_q <= '0;
			idx_q      <= '0;
			len_acc_q  <= '0;
			off_acc_q  <= '0;
			v_s1       <= 1'b0;
		end else begin
			if (acc) begin
				phase_q    <= ph_n;
				len_size_q <= ls_n;
				off_size_q <= os_n;
				idx_q      <= idx_n;
				len_acc_q  <= lacc_n;
				off_acc_q  <= oacc_n;
			end
			if (list_in.ready) v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) ev_s1 <= ev_n;
	end

endmodule

`default_nettype wire

/* sv/rld_extent.sv */
// rld_extent: running cluster, byte scaling and image bound check (stages 2 to 4)
// depends on rld_pkg and rld_out_if
`default_nettype none

module rld_extent (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              v_s1,
	input  wire rld_pkg::run_ev_t  ev_s1,
	output logic                   take,
	input  wire logic [4:0]        cluster_shift,
	input  wire logic [63:0]       image_bytes,
	rld_out_if.source              run_out
);
	import rld_pkg::*;

	logic [63:0] rc_q;
	logic [63:0] base, cl_n;

	logic        v_s2, v_s3, v_s4;
	logic        rdy2, rdy3, rdy4;

	logic        run_s2, run_s3;
	status_t     status_s2, status_s3, status_s4;
	logic [63:0] cl_s2, len_s2;
	logic [63:0] cl_s3, end_s3, sb_s3, lb_s3;
	logic [63:0] cl_s4, sb_s4, lb_s4;
	logic [63:0] end_b;

	assign rdy4 = !v_s4 || run_out.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	// bytes without a result only touch the running cluster
	assign take = v_s1 && (rdy2 || !ev_s1.res);

	assign base  = ev_s1.clr ? 64'd0 : rc_q;
	assign cl_n  = base + ev_s1.off;
	assign end_b = end_s3 << cluster_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (take) rc_q <= ev_s1.run ? cl_n : base;
			if (rdy2) v_s2 <= take && ev_s1.res;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && take) begin
			run_s2    <= ev_s1.run;
			status_s2 <= ev_s1.status;
			cl_s2     <= ev_s1.run ? cl_n : 64'd0;
			len_s2    <= ev_s1.run ? ev_s1.len : 64'd0;
		end
		if (rdy3 && v_s2) begin
			run_s3    <= run_s2;
			status_s3 <= status_s2;
			cl_s3     <= cl_s2;
			end_s3    <= cl_s2 + len_s2;
			sb_s3     <= cl_s2 << cluster_shift;
			lb_s3     <= len_s2 << cluster_shift;
		end
		if (rdy4 && v_s3) begin
			if (run_s3) status_s4 <= (end_b > image_bytes) ? ST_OUTSIDE : ST_EXTENT;
			else status_s4 <= status_s3;
			cl_s4 <= cl_s3;
			sb_s4 <= sb_s3;
			lb_s4 <= lb_s3;
		end
	end

	assign run_out.valid          = v_s4;
	assign run_out.status         = 3'(status_s4);
	assign run_out.start_byte     = sb_s4;
	assign run_out.length_byte    = lb_s4;
	assign run_out.cluster_number = cl_s4;

`ifndef SYNTHESIS
	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		run_out.valid && status_s4 != ST_EXTENT && status_s4 != ST_OUTSIDE
		|-> sb_s4 == 64'd0 && lb_s4 == 64'd0 && cl_s4 == 64'd0)
		else $error("error result carries non-zero extent fields");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy3 |=> v_s2 && $stable(cl_s2) && $stable(len_s2))
		else $error("stage 2 lost its run while stalled");

	a_list_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && ev_s1.clr && !ev_s1.run |=> rc_q == 64'd0)
		else $error("running cluster not cleared at list start");
`endif

endmodule

`default_nettype wire

/* sv/run_list_decoder.sv */
// run_list_decoder: run list byte decoder, top level
// depends on rld_pkg, rld_if, rld_regs, rld_parser, rld_extent
//
// list_in carries one run list byte per transaction, with list_start on the
// first byte of a list and list_last on the last available one. run_out
// carries one transaction per decoded run (extent or out of image) and one
// for the end marker, a zero-length run or a truncated list.
// Throughput is one byte per cycle unless a result byte waits on a stalled
// run_out: the parser consumes each byte in the cycle it is accepted, and the
// running cluster add, the shifts and the image bound compare sit in three further register stages.
// A result is registered in the parser stage and then in stages 2, 3 and 4
// before it is valid on run_out.
// If run_out stalls, the stages fill up; list_in keeps accepting bytes that
// yield no result and stops only when a result byte has nowhere to go.
// Reset clears the parser, the running cluster and all valid flags, and sets
// cluster_shift to 12 and image_bytes to all ones. Configuration is written
// over the apb port (cluster_shift at 0x0, image_bytes at 0x8) while idle.
`default_nettype none

module run_list_decoder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	rld_in_if.sink                          list_in,
	rld_out_if.source                       run_out,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rld_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rld_pkg::DATA_W-1:0] pwdata,
	output logic      [rld_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import rld_pkg::*;

	logic        v_s1;
	run_ev_t     ev_s1;
	logic        take;
	logic [4:0]  cluster_shift;
	logic [63:0] image_bytes;

	rld_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.cluster_shift (cluster_shift),
		.image_bytes   (image_bytes)
	);

	rld_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.list_in (list_in),
		.take    (take),
		.v_s1    (v_s1),
		.ev_s1   (ev_s1)
	);

	rld_extent u_extent (
		.clk           (clk),
		.arst_n        (arst_n),
		.v_s1          (v_s1),
		.ev_s1         (ev_s1),
		.take          (take),
		.cluster_shift (cluster_shift),
		.image_bytes   (image_bytes),
		.run_out       (run_out)
	);

endmodule

`default_nettype wire

/* test/run_list_decoder_check.sv */
`timescale 1ns / 1ps
// run_list_decoder_check: decodes the accepted list bytes on its own, tracks the
// apb register writes and compares every run transaction against its prediction
// depends on rld_pkg and rld_if
module run_list_decoder_check (
	input  logic                       clk,
	input  logic                       arst_n,
	rld_in_if                          list_in,
	rld_out_if                         run_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rld_pkg::ADDR_W-1:0] paddr,
	input  logic [rld_pkg::DATA_W-1:0] pwdata,
	input  logic                       pready,
	output int                         fails,
	output int                         outstanding,
	output int                         checked
);
	import rld_pkg::*;

	typedef struct {
		status_t     status;
		logic [63:0] start_byte;
		logic [63:0] length_byte;
		logic [63:0] cluster_number;
	} run_rec_t;

	run_rec_t    expected_runs[$];

	logic [4:0]  shift;
	logic [63:0] image_size;
	phase_t      phase;
	logic [3:0]  len_size;
	logic [3:0]  off_size;
	logic [3:0]  idx;
	logic [63:0] len_acc;
	logic [63:0] off_acc;
	logic [63:0] cluster;

	function automatic logic [3:0] clamp_nibble(logic [3:0] n);
		return (n > MAX_FIELD) ? MAX_FIELD : n;
	endfunction

	task automatic push_run(status_t st, logic [63:0] sb, logic [63:0] lb, logic [63:0] cn);
		run_rec_t r;
		r.status = st;
		r.start_byte = sb;
		r.length_byte = lb;
		r.cluster_number = cn;
		expected_runs.push_back(r);
	endtask

	task automatic clear_parser();
		phase = PH_HEADER;
		len_size = '0;
		off_size = '0;
		idx = '0;
		len_acc = '0;
		off_acc = '0;
	endtask

	// last byte of a run is in: judge it
	task automatic close_run();
		logic [63:0] rel;
		logic [63:0] end_pos;
		int nbits;
		if (len_acc == 0) begin
			push_run(ST_ZERO_LEN, '0, '0, '0);
			phase = PH_HALTED;
			return;
		end
		rel = off_acc;
		nbits = int'(off_size) * 8;
		// short offset fields are sign extended, a full 8-byte field is taken as is
		if (off_size > 0 && off_size < MAX_FIELD && rel[nbits-1])
			rel = rel | ({64{1'b1}} << nbits);
		cluster = cluster + rel;
		end_pos = (cluster + len_acc) << shift;
		push_run((end_pos > image_size) ? ST_OUTSIDE : ST_EXTENT,
			cluster << shift, len_acc << shift, cluster);
		phase = PH_HEADER;
		idx = '0;
		len_acc = '0;
		off_acc = '0;
	endtask

	task automatic decode_byte(logic [7:0] b, logic start, logic last);
		bit made;
		made = 0;
		if (start) begin
			cluster = '0;
			clear_parser();
		end
		case (phase)
			PH_HEADER: begin
				len_size = clamp_nibble(b[3:0]);
				off_size = clamp_nibble(b[7:4]);
				idx = '0;
				len_acc = '0;
				off_acc = '0;
				if (len_size == 0) begin
					push_run(ST_END, '0, '0, '0);
					phase = PH_HALTED;
					return;
				end
				phase = PH_LENGTH;
			end
			PH_LENGTH: begin
				len_acc = len_acc | (64'(b) << (8 * idx[2:0]));
				idx = idx + 1'b1;
				if (idx >= len_size) begin
					idx = '0;
					if (off_size == 0) begin
						close_run();
						made = 1;
					end else begin
						phase = PH_OFFSET;
					end
				end
			end
			PH_OFFSET: begin
				off_acc = off_acc | (64'(b) << (8 * idx[2:0]));
				idx = idx + 1'b1;
				if (idx >= off_size) begin
					close_run();
					made = 1;
				end
			end
			default: return;
		endcase
		if (last) begin
			if (!made)
				push_run(ST_TRUNC, '0, '0, '0);
			phase = PH_HALTED;
		end
	endtask

	task automatic compare_run();
		run_rec_t want;
		if (expected_runs.size() == 0) begin
			$error("run transaction with none expected: status %0d start_byte %h",
				run_out.status, run_out.start_byte);
			fails++;
			return;
		end
		want = expected_runs.pop_front();
		checked++;
		if (run_out.status !== want.status) begin
			$error("status expected %0d got %0d", want.status, run_out.status);
			fails++;
		end
		if (run_out.start_byte !== want.start_byte) begin
			$error("start_byte expected %h got %h", want.start_byte, run_out.start_byte);
			fails++;
		end
		if (run_out.length_byte !== want.length_byte) begin
			$error("length_byte expected %h got %h", want.length_byte, run_out.length_byte);
			fails++;
		end
		if (run_out.cluster_number !== want.cluster_number) begin
			$error("cluster_number expected %h got %h", want.cluster_number,
				run_out.cluster_number);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift = CLUSTER_SHIFT_RST;
			image_size = IMAGE_BYTES_RST;
			cluster = '0;
			clear_parser();
			expected_runs.delete();
			fails = 0;
			checked = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == REG_CLUSTER_SHIFT)
					shift = pwdata[4:0];
				else
					image_size = pwdata;
			end
			if (list_in.valid && list_in.ready)
				decode_byte(list_in.list_byte, list_in.list_start, list_in.list_last);
			if (run_out.valid && run_out.ready)
				compare_run();
			outstanding = expected_runs.size();
		end
	end

endmodule

/* test/run_list_decoder_test.sv */
`timescale 1ns / 1ps
// run_list_decoder_test: feeds run lists and register settings to the decoder,
// with run_list_decoder_check predicting and comparing the run transactions
// depends on rld_pkg, rld_if, run_list_decoder and run_list_decoder_check
module run_list_decoder_test;
	import rld_pkg::*;

	localparam logic [ADDR_W-1:0] SHIFT_ADDR = {REG_CLUSTER_SHIFT, 3'b000};
	localparam logic [ADDR_W-1:0] IMAGE_ADDR = {REG_IMAGE_BYTES, 3'b000};
	localparam int MAX_IDLE        = 14;
	localparam int BYTES_PER_PHASE = 130;
	localparam int NUM_PHASES      = 6;
	localparam int DRAIN_CYCLES    = 10;
	localparam int LONG_STALL      = 300;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int fails;
	int outstanding;
	int checked;
	bit tx_idle;
	bit rx_idle;
	int stall_req = 0;
	int lists_sent = 0;
	int bytes_sent = 0;

	rld_in_if  list_in();
	rld_out_if run_out();

	run_list_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.list_in (list_in),
		.run_out (run_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	run_list_decoder_check run_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.list_in     (list_in),
		.run_out     (run_out),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.fails       (fails),
		.outstanding (outstanding),
		.checked     (checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("run_list_decoder_test: errors");
		$finish;
	end

	// result side: random hold-off per transaction when rx_idle, plus one long stall on request
	initial begin
		int gap;
		run_out.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
			if (stall_req > 0) begin
				gap = stall_req;
				stall_req = 0;
			end
			if (gap > 0) begin
				run_out.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			run_out.ready <= 1'b1;
			do @(posedge clk); while (!run_out.valid);
			@(negedge clk);
		end
	end

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_byte(logic [7:0] b, logic start, logic last);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			list_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		list_in.valid <= 1'b1;
		list_in.list_byte <= b;
		list_in.list_start <= start;
		list_in.list_last <= last;
		do @(posedge clk); while (!list_in.ready);
		@(negedge clk);
	endtask

	task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(logic [4:0] shift, logic [63:0] image);
		apb_write(SHIFT_ADDR, DATA_W'(shift));
		apb_write(IMAGE_ADDR, image);
	endtask

	task automatic wait_drained();
		list_in.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// one list of random runs, closed by an end marker, a cut or a last run
	task automatic send_list();
		logic [7:0] body[$];
		int runs, lo, hi, lsz, osz, ending, tail, r, i;
		bit zero_len, with_start, last_on_end;
		runs = $urandom_range(1, 6);
		for (r = 0; r < runs; r++) begin
			lo = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 4);
			hi = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
			lsz = (lo > 8) ? 8 : lo;
			osz = (hi > 8) ? 8 : hi;
			zero_len = ($urandom_range(0, 24) == 0);
			body.push_back({4'(hi), 4'(lo)});
			for (i = 0; i < lsz; i++)
				body.push_back(zero_len ? 8'h00 : 8'($urandom_range(0, 255)));
			for (i = 0; i < osz; i++)
				body.push_back(8'($urandom_range(0, 255)));
		end
		ending = $urandom_range(0, 9);
		last_on_end = 1'b1;
		if (ending < 6) begin
			body.push_back({4'($urandom_range(0, 15)), 4'h0});
			last_on_end = 1'($urandom_range(0, 1));
		end else if (ending < 8) begin
			body = body[0:$urandom_range(0, body.size() - 1)];
		end
		with_start = ($urandom_range(0, 19) != 0);
		for (i = 0; i < body.size(); i++)
			send_byte(body[i], with_start && i == 0, last_on_end && i == body.size() - 1);
		lists_sent++;
		bytes_sent += body.size();
		// trailing noise, mostly ignored by a halted parser
		tail = $urandom_range(0, 2);
		for (i = 0; i < tail; i++)
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
				1'($urandom_range(0, 1)));
	endtask

	initial begin
		int ph, start_count;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		list_in.valid = 1'b0;
		list_in.list_byte = '0;
		list_in.list_start = 1'b0;
		list_in.list_last = 1'b0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed lists on the reset settings
		// no list_start after reset, the run closes on the last byte
		send_byte(8'h11, 1'b0, 1'b0);
		send_byte(8'h05, 1'b0, 1'b0);
		send_byte(8'h10, 1'b0, 1'b1);
		send_byte(8'h22, 1'b0, 1'b0);
		// both nibbles above eight: eight length bytes, eight offset bytes
		send_byte(8'h99, 1'b1, 1'b0);
		repeat (8) send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		repeat (7) send_byte(8'h00, 1'b0, 1'b0);
		// empty offset, then a negative one-byte offset
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h07, 1'b0, 1'b0);
		send_byte(8'h11, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		send_byte(8'hF0, 1'b0, 1'b0);
		// zero length run
		send_byte(8'h11, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		// list cut after the length field, before its offset field, then on a header
		send_byte(8'h21, 1'b1, 1'b0);
		send_byte(8'h01, 1'b0, 1'b1);
		send_byte(8'h01, 1'b1, 1'b1);
		send_byte(8'h00, 1'b1, 1'b1);
		wait_drained();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: set_config(5'd9, '1);
				1: set_config(5'd21, {16'h0, 16'($urandom), 32'($urandom)});
				2: set_config(5'd0, '0);
				3: set_config(5'd31, {32'($urandom), 32'($urandom)});
				4: set_config(5'd12, 64'h1 << 40);
				default: set_config(5'($urandom_range(9, 21)), {24'h0, 8'($urandom), 32'($urandom)});
			endcase
			tx_idle = (ph == 0) ? 1'b1 : (ph == 2 || ph == 3) ? 1'b0 :
				1'($urandom_range(0, 1));
			rx_idle = (ph == 0) ? 1'b1 : (ph == 3) ? 1'b0 : 1'($urandom_range(0, 1));
			if (ph == 2)
				stall_req = LONG_STALL;
			start_count = bytes_sent;
			while (bytes_sent - start_count < BYTES_PER_PHASE)
				send_list();
			wait_drained();
		end

		$display("summary: %0d lists, %0d list bytes, %0d run transactions checked",
			lists_sent, bytes_sent, checked);
		$display("summary: %0d register settings incl. shifts 0 and 31, images 0 and max",
			NUM_PHASES + 1);
		if (fails == 0)
			$display("run_list_decoder_test: clean");
		else
			$display("run_list_decoder_test: errors");
		$finish;
	end

endmodule
